FILE: sv/skh_pkg.sv
// ----------------------------------------------------------------------------
// skh_pkg: shared types and constants of the string key hash set
// Sizes, FNV-1a constants, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package skh_pkg;

  localparam int unsigned SLOT_COUNT    = 4096;
  localparam int unsigned POOL_BYTES    = 131072;
  localparam int unsigned MAX_KEY_BYTES = 512;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int POOL_W = $clog2(POOL_BYTES);
  localparam int FILL_W = POOL_W + 1;
  localparam int KBUF_W = $clog2(MAX_KEY_BYTES);
  localparam int KLEN_W = KBUF_W + 1;
  localparam int CNT_W  = SLOT_W;
  localparam int STE_W  = FILL_W - 1 + 1;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  localparam logic [CNT_W-1:0] ENTRY_LIMIT = CNT_W'(SLOT_COUNT / 2);

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_DECIDE,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_INS_RD,
    S_INS_WR,
    S_DONE
  } state_t;

endpackage

FILE: sv/skh_ram.sv
// ----------------------------------------------------------------------------
// skh_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module skh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/skh_hash.sv
// ----------------------------------------------------------------------------
// skh_hash: FNV-1a hash step
// Folds one byte into the running hash; the multiply is registered.
// ----------------------------------------------------------------------------
module skh_hash
  import skh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic        step,
  input  logic [7:0]  byte_in,
  output logic [31:0] hash
);

  logic [31:0] hash_r, hash_nxt;

  always_comb begin
    hash_nxt = hash_r;
    if (clr) begin
      hash_nxt = HASH_BASIS;
    end else if (step) begin
      hash_nxt = (hash_r ^ {24'd0, byte_in}) * HASH_PRIME;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

FILE: sv/string_key_hash_set.sv
// ----------------------------------------------------------------------------
// string_key_hash_set: FNV-1a hashed string set with linear probing
// Keys arrive a byte per transfer; on the last byte the slot table is probed
// and the key is looked up or inserted into a byte pool.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Ports
//  -------  -------------------  ------------------------------------------
//  in       start & !busy        in_operation, in_key_byte, in_key_last
//  out      out_valid (1 cycle)  out_status, out_slot_index,
//                                out_entry_count, out_full_seen
//
// After reset the slot table is cleared, one slot a cycle, while busy stays
// high. A key byte that is not the last is transferred, then hashed and
// written to the key buffer. The last byte then probes: each slot is read,
// then checked, and each compared byte is read, then checked; an insert
// copies the key to the pool byte by byte, each read, then written. Results
// are shown for one cycle and cannot be stalled.
module string_key_hash_set
  import skh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [7:0]        in_key_byte,
  input  logic              in_key_last,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic              out_full_seen
);

  state_t state_r, state_nxt;

  // Per-key state.
  logic              key_busy_r, key_busy_nxt;
  logic              key_op_r, key_op_nxt;
  logic              key_over_r, key_over_nxt;
  logic              key_ended_r, key_ended_nxt;
  logic [KLEN_W-1:0] key_len_r, key_len_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;

  // Global set state.
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W:0]    count_r, count_nxt;
  logic              full_r, full_nxt;

  // Probe state: current slot, probes made, pool pointer and compare index.
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W:0]   probes_r, probes_nxt;
  logic [FILL_W-1:0] pptr_r, pptr_nxt;
  logic [KLEN_W-1:0] kidx_r, kidx_nxt;
  logic [2:0]        status_r, status_nxt;
  logic              emit;

  logic        hash_clr, hash_step;
  logic [31:0] hash;

  // Memory ports.
  logic              st_we;
  logic [SLOT_W-1:0] st_addr;
  logic [STE_W-1:0]  st_wdata, st_rdata;
  logic              kb_we;
  logic [KBUF_W-1:0] kb_addr;
  logic [7:0]        kb_wdata, kb_rdata;
  logic              kp_we;
  logic [POOL_W-1:0] kp_addr;
  logic [7:0]        kp_wdata, kp_rdata;

  skh_hash u_hash (
    .clk(clk), .rst_n(rst_n), .clr(hash_clr), .step(hash_step),
    .byte_in(byte_r), .hash(hash)
  );

  skh_ram #(.WIDTH(STE_W), .DEPTH(SLOT_COUNT)) u_slots (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
  );

  skh_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_kbuf (
    .clk(clk), .we(kb_we), .addr(kb_addr), .wdata(kb_wdata), .rdata(kb_rdata)
  );

  skh_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (
    .clk(clk), .we(kp_we), .addr(kp_addr), .wdata(kp_wdata), .rdata(kp_rdata)
  );

  assign busy = (state_r != S_IDLE);

  always_comb begin
    logic [7:0]        want;
    logic [FILL_W+KLEN_W:0] need;
    state_nxt     = state_r;
    key_busy_nxt  = key_busy_r;
    key_op_nxt    = key_op_r;
    key_over_nxt  = key_over_r;
    key_ended_nxt = key_ended_r;
    key_len_nxt   = key_len_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    full_nxt      = full_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    pptr_nxt      = pptr_r;
    kidx_nxt      = kidx_r;
    status_nxt    = status_r;
    emit          = 1'b0;
    hash_clr      = 1'b0;
    hash_step     = 1'b0;
    st_we         = 1'b0;
    st_addr       = slot_r;
    st_wdata      = '0;
    kb_we         = 1'b0;
    kb_addr       = kidx_r[KBUF_W-1:0];
    kb_wdata      = byte_r;
    kp_we         = 1'b0;
    kp_addr       = pptr_r[POOL_W-1:0];
    kp_wdata      = kb_rdata;
    want          = (kidx_r < key_len_r) ? kb_rdata : 8'd0;
    need          = (FILL_W+KLEN_W+1)'(fill_r) + (FILL_W+KLEN_W+1)'(key_len_r)
                    + (FILL_W+KLEN_W+1)'(1);

    case (state_r)
      S_CLEAR: begin
        // Sweep zeros through the slot table after reset.
        st_we    = 1'b1;
        slot_nxt = slot_r + SLOT_W'(1);
        if (slot_r == SLOT_W'(SLOT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          byte_nxt  = in_key_byte;
          last_nxt  = in_key_last;
          state_nxt = S_HASH;
          if (!key_busy_r) begin
            key_busy_nxt = 1'b1;
            key_op_nxt   = in_operation;
          end
        end
      end
      S_HASH: begin
        if (!key_ended_r) begin
          if (byte_r == 8'd0) begin
            key_ended_nxt = 1'b1;
          end else begin
            hash_step = 1'b1;
            if (key_len_r >= KLEN_W'(MAX_KEY_BYTES)) begin
              key_over_nxt = 1'b1;
            end else begin
              kb_we       = 1'b1;
              kb_addr     = key_len_r[KBUF_W-1:0];
              key_len_nxt = key_len_r + KLEN_W'(1);
            end
          end
        end
        state_nxt = last_r ? S_DECIDE : S_IDLE;
      end
      S_DECIDE: begin
        slot_nxt   = hash[SLOT_W-1:0];
        probes_nxt = '0;
        if (key_over_r) begin
          status_nxt = ST_TOO_LONG;
          slot_nxt   = '0;
          state_nxt  = S_DONE;
        end else if (key_op_r && ((count_r >= (CNT_W+1)'(ENTRY_LIMIT)) ||
                     (need > (FILL_W+KLEN_W+1)'(POOL_BYTES)))) begin
          status_nxt = ST_FULL;
          full_nxt   = 1'b1;
          slot_nxt   = '0;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        if (probes_r == (SLOT_W+1)'(SLOT_COUNT)) begin
          slot_nxt  = '0;
          state_nxt = S_DONE;
          if (key_op_r) begin
            status_nxt = ST_FULL;
            full_nxt   = 1'b1;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end else begin
          state_nxt = S_SLOT_CHK;
        end
      end
      S_SLOT_CHK: begin
        if (st_rdata == '0) begin
          if (key_op_r) begin
            kidx_nxt  = '0;
            pptr_nxt  = fill_r;
            state_nxt = S_INS_RD;
          end else begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end
        end else begin
          pptr_nxt  = FILL_W'(st_rdata - STE_W'(1));
          kidx_nxt  = '0;
          state_nxt = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        // Key buffer and pool are both read here.
        state_nxt = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (pptr_r >= FILL_W'(POOL_BYTES) || kp_rdata != want) begin
          slot_nxt   = slot_r + SLOT_W'(1);
          probes_nxt = probes_r + (SLOT_W+1)'(1);
          state_nxt  = S_SLOT_RD;
        end else if (kidx_r == key_len_r) begin
          status_nxt = key_op_r ? ST_DUPLICATE : ST_FOUND;
          state_nxt  = S_DONE;
        end else begin
          kidx_nxt  = kidx_r + KLEN_W'(1);
          pptr_nxt  = pptr_r + FILL_W'(1);
          state_nxt = S_CMP_RD;
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        // Copy the buffered key, then its terminator.
        kp_we    = 1'b1;
        kp_wdata = want;
        if (kidx_r == key_len_r) begin
          st_we      = 1'b1;
          st_wdata   = STE_W'(fill_r) + STE_W'(1);
          fill_nxt   = FILL_W'(need);
          count_nxt  = count_r + (CNT_W+1)'(1);
          status_nxt = ST_INSERTED;
          state_nxt  = S_DONE;
        end else begin
          kidx_nxt  = kidx_r + KLEN_W'(1);
          pptr_nxt  = pptr_r + FILL_W'(1);
          state_nxt = S_INS_RD;
        end
      end
      S_DONE: begin
        emit          = 1'b1;
        hash_clr      = 1'b1;
        key_busy_nxt  = 1'b0;
        key_op_nxt    = 1'b0;
        key_over_nxt  = 1'b0;
        key_ended_nxt = 1'b0;
        key_len_nxt   = '0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      key_busy_r  <= 1'b0;
      key_op_r    <= 1'b0;
      key_over_r  <= 1'b0;
      key_ended_r <= 1'b0;
      key_len_r   <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      full_r      <= 1'b0;
      slot_r      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_busy_r  <= key_busy_nxt;
      key_op_r    <= key_op_nxt;
      key_over_r  <= key_over_nxt;
      key_ended_r <= key_ended_nxt;
      key_len_r   <= key_len_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
      slot_r      <= slot_nxt;
      out_valid   <= emit;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    probes_r <= probes_nxt;
    pptr_r   <= pptr_nxt;
    kidx_r   <= kidx_nxt;
    status_r <= status_nxt;
    if (emit) begin
      out_status      <= status_r;
      out_slot_index  <= slot_r;
      out_entry_count <= count_r[CNT_W-1:0];
      out_full_seen   <= full_r;
    end
  end

endmodule
